// ===== sv/bpa_pkg.sv =====
// Shared types and constants for the buffer pool allocator.
// No dependencies; every other file imports this package.
package bpa_pkg;

  localparam int MAX_BUFFERS = 256;
  localparam int ID_LIMIT    = 256;
  localparam int ID_W        = $clog2(ID_LIMIT);
  localparam int COUNT_W     = 9;
  localparam int TALLY_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int STATUS_W    = 3;

  localparam logic [COUNT_W-1:0] CAP_COUNT =
    COUNT_W'((MAX_BUFFERS < ID_LIMIT) ? MAX_BUFFERS : ID_LIMIT);
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_POOL = 3'd0,
    ST_OVER = 3'd1,
    ST_DENY = 3'd2,
    ST_REL  = 3'd3,
    ST_IGN  = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Write and clear controls for the free store.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] addr;
    logic [ID_W-1:0] data;
    logic            clear;
  } store_ctl_t;

endpackage

// ===== sv/bpa_free_store.sv =====
// Free stack storage: 256 x 8 synchronous RAM plus per-entry valid bits.
// An entry never written since reset or refill reads as its own index. Uses bpa_pkg.
module bpa_free_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [bpa_pkg::ID_W-1:0] rd_addr,
  input  bpa_pkg::store_ctl_t      ctl,
  output logic [bpa_pkg::ID_W-1:0] rd_data
);
  import bpa_pkg::*;

  logic [ID_W-1:0] mem [ID_LIMIT];
  logic [ID_LIMIT-1:0] valid_r;
  logic [ID_W-1:0] q_r;
  logic [ID_W-1:0] addr_q_r;
  logic            vld_q_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.addr] <= ctl.data;
    end
    if (rd_en) begin
      q_r      <= mem[rd_addr];
      addr_q_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r <= '0;
    end else if (ctl.we) begin
      valid_r[ctl.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
    end else if (rd_en) begin
      vld_q_r <= valid_r[rd_addr];
    end
  end

  // Unwritten entries read as the index itself.
  assign rd_data = vld_q_r ? q_r : addr_q_r;

endmodule

// ===== sv/buffer_pool_allocator.sv =====
// Buffer pool allocator: free stack of fixed buffer indices with overflow accounting.
// Flow: a beat is accepted in the idle state, which also issues the free store read; the
// result is registered in the execute state once the result slot is free.
// A new request is taken only after the current one completes and the FSM is idle again.
// Reset (synchronous, rst_n low): pool of 256, unlimited overflow, all buffers free,
// overflow tally zero; the free store valid bits clear at once, no clearing pass.
module buffer_pool_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [bpa_pkg::ID_W-1:0]       in_buffer_id,
  input  logic                           in_is_overflow,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status,
  output logic [bpa_pkg::ID_W-1:0]       out_granted_id,
  output logic [bpa_pkg::COUNT_W-1:0]    out_pool_total,
  output logic [bpa_pkg::COUNT_W-1:0]    out_available_count,
  output logic [bpa_pkg::COUNT_W-1:0]    out_acquired_count,
  output logic [bpa_pkg::TALLY_W-1:0]    out_overflow_in_use
);
  import bpa_pkg::*;

  // Control state
  fsm_t                state_r, state_nxt;
  logic [COUNT_W-1:0]  pool_r;
  logic [TALLY_W-1:0]  limit_r;
  logic [COUNT_W-1:0]  top_r, top_nxt;
  logic [TALLY_W-1:0]  tally_r, tally_nxt;
  logic                out_valid_r;

  // Latched request
  logic                mode_r;
  logic [ID_W-1:0]     id_r;
  logic                ovf_r;

  // Result register
  status_t             status_r, status_nxt;
  logic [ID_W-1:0]     granted_r, granted_nxt;
  logic [COUNT_W-1:0]  avail_r;
  logic [COUNT_W-1:0]  acq_r;
  logic [TALLY_W-1:0]  ovf_use_r;
  logic [COUNT_W-1:0]  pool_out_r;

  logic                in_beat;
  logic                exec_done;
  logic                rd_en;
  logic [ID_W-1:0]     rd_addr;
  logic [ID_W-1:0]     rd_data;
  store_ctl_t          ctl;
  logic [COUNT_W-1:0]  cfg_pool;
  logic                room_ok;
  logic                push_ok;

  assign in_beat = in_valid && !in_stall;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_beat) state_nxt = FSM_EXEC;
      FSM_EXEC: if (exec_done) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // FSM outputs: take a beat only when idle, finish once the result slot is free
  always_comb begin
    in_stall  = 1'b1;
    exec_done = 1'b0;
    rd_en     = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      FSM_EXEC: begin
        exec_done = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  // Prefetch the entry under the top of stack for a possible pop
  assign rd_addr = ID_W'(top_r - COUNT_W'(1));

  bpa_free_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

  // Clamp a written pool size into [1, CAP_COUNT]
  always_comb begin
    cfg_pool = cfg_data[COUNT_W-1:0];
    if (cfg_pool == '0) cfg_pool = COUNT_W'(1);
    if (cfg_pool > CAP_COUNT) cfg_pool = CAP_COUNT;
  end

  // Overflow budget: pool + tally + 1 must stay within the limit (a zero limit is unlimited)
  assign room_ok = (limit_r == '0) ||
                   ((17'(pool_r) + 17'(tally_r) + 17'd1) <= 17'(limit_r));
  assign push_ok = ({1'b0, id_r} < pool_r) && (top_r < pool_r);

  // Execute the latched request against the stack and the tally
  always_comb begin
    top_nxt     = top_r;
    tally_nxt   = tally_r;
    granted_nxt = '0;
    status_nxt  = ST_IGN;
    ctl         = '0;
    if (exec_done) begin
      if (!mode_r) begin
        priority if (top_r != '0) begin
          top_nxt     = top_r - COUNT_W'(1);
          granted_nxt = rd_data;
          status_nxt  = ST_POOL;
        end else if (room_ok) begin
          // saturate the tally, the grant still stands
          if (tally_r != TALLY_MAX) tally_nxt = tally_r + TALLY_W'(1);
          status_nxt = ST_OVER;
        end else begin
          status_nxt = ST_DENY;
        end
      end else if (ovf_r) begin
        if (tally_r != '0) begin
          tally_nxt  = tally_r - TALLY_W'(1);
          status_nxt = ST_REL;
        end
      end else if (push_ok) begin
        ctl.we     = 1'b1;
        ctl.addr   = top_r[ID_W-1:0];
        ctl.data   = id_r;
        top_nxt    = top_r + COUNT_W'(1);
        status_nxt = ST_REL;
      end
    end
    // refill: drop every written entry back to its own index
    if (cfg_we && cfg_index == CFG_POOL_COUNT) ctl.clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      pool_r      <= CAP_COUNT;
      limit_r     <= '0;
      top_r       <= CAP_COUNT;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tally_r <= tally_nxt;
      // a pool size write refills the stack
      if (cfg_we && cfg_index == CFG_POOL_COUNT) begin
        pool_r <= cfg_pool;
        top_r  <= cfg_pool;
      end else begin
        top_r  <= top_nxt;
      end
      if (cfg_we && cfg_index == CFG_LIMIT) begin
        limit_r <= cfg_data[TALLY_W-1:0];
      end
      // hold the result until taken, then drop it unless a new one lands
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      mode_r <= in_mode;
      id_r   <= in_buffer_id;
      ovf_r  <= in_is_overflow;
    end
    if (exec_done) begin
      status_r   <= status_nxt;
      granted_r  <= granted_nxt;
      avail_r    <= top_nxt;
      acq_r      <= pool_r - top_nxt;
      ovf_use_r  <= tally_nxt;
      pool_out_r <= pool_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_granted_id      = granted_r;
  assign out_pool_total      = pool_out_r;
  assign out_available_count = avail_r;
  assign out_acquired_count  = acq_r;
  assign out_overflow_in_use = ovf_use_r;

endmodule
